/* rtl/kee_pkg.sv */
package kee_pkg;

	localparam int NUM_KEYS          = 13;
	localparam int NUM_LANES         = NUM_KEYS + 2;
	localparam int LANE_ENTER        = NUM_KEYS;
	localparam int LANE_DELETE       = NUM_KEYS + 1;
	localparam int CODE_W            = 4;
	localparam int QUEUE_DEPTH_DEF   = 16;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE    = 4'd0,
		EV_UP      = 4'd1,
		EV_DOWN    = 4'd2,
		EV_LEFT    = 4'd3,
		EV_RIGHT   = 4'd4,
		EV_APPROVE = 4'd5,
		EV_DENY    = 4'd6,
		EV_MENU    = 4'd7,
		EV_DEMO    = 4'd8,
		EV_BACK    = 4'd9
	} event_t;

	// Lane order: the thirteen mapped keys from bit 0 upward, then Enter, then Delete.
	localparam event_t LANE_CODE [NUM_LANES] = '{
		EV_UP, EV_DOWN, EV_LEFT, EV_RIGHT,
		EV_APPROVE, EV_APPROVE, EV_DENY, EV_DENY,
		EV_MENU, EV_MENU, EV_DEMO, EV_DEMO,
		EV_BACK,
		EV_APPROVE, EV_BACK
	};

	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] code;
	} push_t;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} rd_t;

endpackage

/* rtl/kee_cmd_if.sv */
interface kee_cmd_if;

	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [kee_pkg::NUM_KEYS-1:0]  held_keys;
	logic                          fn_held;
	logic                          enter_held;
	logic                          delete_held;

	modport source (
		output valid, mode, held_keys, fn_held, enter_held, delete_held,
		input  ready
	);

	modport sink (
		input  valid, mode, held_keys, fn_held, enter_held, delete_held,
		output ready
	);

endinterface

/* rtl/kee_evt_if.sv */
interface kee_evt_if;

	logic                        valid;
	logic                        ready;
	logic [kee_pkg::CODE_W-1:0]  event_code;

	modport source (
		output valid, event_code,
		input  ready
	);

	modport sink (
		input  valid, event_code,
		output ready
	);

endinterface

/* rtl/kee_lane.sv */
module kee_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic cur,
	input  logic arm,
	output logic rise
);

	logic prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
		end else if (load) begin
			prev_q <= cur;
		end
	end

	assign rise = cur & ~prev_q & arm;

endmodule

/* rtl/kee_merge.sv */
module kee_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [kee_pkg::NUM_LANES-1:0] rise,
	output logic                          busy,
	output kee_pkg::push_t                push
);

	logic [kee_pkg::NUM_LANES-1:0] mask_q;
	logic [kee_pkg::NUM_LANES-1:0] lowest;
	logic [kee_pkg::CODE_W-1:0]    code;

	assign lowest = mask_q & (~mask_q + 1'b1);

	always_comb begin
		code = '0;
		for (int i = 0; i < kee_pkg::NUM_LANES; i++) begin
			if (lowest[i]) begin
				code = code | kee_pkg::LANE_CODE[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= rise;
		end else begin
			mask_q <= mask_q & ~lowest;
		end
	end

	assign busy      = |mask_q;
	assign push.en   = |mask_q;
	assign push.code = code;

	// Pending lanes only ever drain between loads.
	assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> (mask_q & ~$past(mask_q)) == '0)
		else $error("merge mask gained a lane without a load");

endmodule

/* rtl/kee_ring.sv */
module kee_ring #(
	parameter int QUEUE_DEPTH = kee_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kee_pkg::push_t push,
	input  logic           pop_en,
	output kee_pkg::rd_t   rd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [kee_pkg::CODE_W-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           rp_q;
	logic [PTR_W-1:0]           wp_next;
	logic [PTR_W-1:0]           rp_next;
	logic                       full;
	logic                       empty;
	logic                       rd_hit_q;
	logic [kee_pkg::CODE_W-1:0] rd_code_q;

	assign wp_next = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign full    = (wp_next == rp_q);
	assign empty   = (wp_q == rp_q);

	always_ff @(posedge clk) begin
		if (push.en && !full) begin
			mem[wp_q] <= push.code;
		end
		if (pop_en) begin
			rd_code_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (push.en && !full) begin
				wp_q <= wp_next;
			end
			if (pop_en) begin
				rd_hit_q <= !empty;
				if (!empty) begin
					rp_q <= rp_next;
				end
			end
		end
	end

	assign rd.hit  = rd_hit_q;
	assign rd.code = rd_code_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.en && full) |=> wp_q == $past(wp_q))
		else $error("write pointer moved on a full ring");

	assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q <= PTR_W'(QUEUE_DEPTH - 1)) && (rp_q <= PTR_W'(QUEUE_DEPTH - 1)))
		else $error("ring pointer out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push.en && pop_en))
		else $error("push and pop in the same cycle");

endmodule

/* rtl/key_event_edge_queue.sv */
// Channel  Role    Handshake      Word
// cmd      sink    valid/ready    mode, held_keys, fn_held, enter_held, delete_held
// evt      source  valid/ready    event_code
//
// A scan is accepted and then pushes one new event per cycle, one for each
// rising lane of up to fifteen, and holds the block until the merge stage has drained.
// A pop first does the registered ring read and then waits for the
// output register, which holds a result while the next word is accepted.
// Reset clears the edge flags and ring pointers at once; no clearing pass.
// A stalled evt channel still lets the next word in, but a second pop then
// holds the block until the waiting word has been taken.
module key_event_edge_queue #(
	parameter int QUEUE_DEPTH = kee_pkg::QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	kee_cmd_if.sink  cmd,
	kee_evt_if.source evt
);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t                        state_q;
	logic                          out_valid_q;
	logic [kee_pkg::CODE_W-1:0]    out_code_q;
	logic                          accept;
	logic                          scan_load;
	logic                          pop_en;
	logic                          merge_busy;
	logic [kee_pkg::NUM_LANES-1:0] lane_cur;
	logic [kee_pkg::NUM_LANES-1:0] lane_arm;
	logic [kee_pkg::NUM_LANES-1:0] lane_rise;
	logic                          out_free;
	kee_pkg::push_t                push;
	kee_pkg::rd_t                  rd;

	assign cmd.ready = (state_q == ST_IDLE) && !merge_busy;
	assign accept    = cmd.valid && cmd.ready;
	assign scan_load = accept && !cmd.mode;
	assign pop_en    = accept && cmd.mode;
	assign out_free  = !out_valid_q || evt.ready;

	always_comb begin
		for (int i = 0; i < kee_pkg::NUM_KEYS; i++) begin
			lane_cur[i] = cmd.held_keys[i];
			lane_arm[i] = !cmd.fn_held;
		end
		lane_cur[kee_pkg::LANE_ENTER]  = cmd.enter_held;
		lane_arm[kee_pkg::LANE_ENTER]  = 1'b1;
		lane_cur[kee_pkg::LANE_DELETE] = cmd.delete_held;
		lane_arm[kee_pkg::LANE_DELETE] = 1'b1;
	end

	for (genvar g = 0; g < kee_pkg::NUM_LANES; g++) begin : g_lane
		kee_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (scan_load),
			.cur    (lane_cur[g]),
			.arm    (lane_arm[g]),
			.rise   (lane_rise[g])
		);
	end

	kee_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (scan_load),
		.rise   (lane_rise),
		.busy   (merge_busy),
		.push   (push)
	);

	kee_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop_en (pop_en),
		.rd     (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_code_q  <= kee_pkg::EV_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (evt.ready) begin
						out_valid_q <= 1'b0;
					end
					if (pop_en) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_code_q  <= rd.hit ? rd.code : kee_pkg::EV_NONE;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					if (evt.ready) begin
						out_valid_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_code = out_code_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !merge_busy)
		else $error("pop in progress while events are still being pushed");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int RING_DEPTH = kee_pkg::QUEUE_DEPTH_DEF;
	localparam int KEY_W      = kee_pkg::NUM_KEYS;
	localparam bit MODE_SCAN  = 1'b0;
	localparam bit MODE_POP   = 1'b1;

	class event_ring_predictor;

		logic [KEY_W-1:0]    last_keys;
		bit                  last_enter;
		bit                  last_delete;
		kee_pkg::event_t     slots [RING_DEPTH];
		int                  wr_idx;
		int                  rd_idx;
		kee_pkg::event_t     pending [$];
		int                  errors;

		function new();
			last_keys   = '0;
			last_enter  = 1'b0;
			last_delete = 1'b0;
			wr_idx      = 0;
			rd_idx      = 0;
			errors      = 0;
		endfunction

		function kee_pkg::event_t key_event(int k);
			case (k)
				0:       return kee_pkg::EV_UP;
				1:       return kee_pkg::EV_DOWN;
				2:       return kee_pkg::EV_LEFT;
				3:       return kee_pkg::EV_RIGHT;
				4, 5:    return kee_pkg::EV_APPROVE;
				6, 7:    return kee_pkg::EV_DENY;
				8, 9:    return kee_pkg::EV_MENU;
				10, 11:  return kee_pkg::EV_DEMO;
				default: return kee_pkg::EV_BACK;
			endcase
		endfunction

		function void push(kee_pkg::event_t code);
			int nxt;
			nxt = (wr_idx + 1) % RING_DEPTH;
			if (nxt != rd_idx) begin
				slots[wr_idx] = code;
				wr_idx        = nxt;
			end
		endfunction

		function void note_word(bit mode, logic [KEY_W-1:0] keys, bit fn, bit enter,
				bit del);
			logic [KEY_W-1:0] rising;
			if (mode == MODE_POP) begin
				if (rd_idx != wr_idx) begin
					pending.push_back(slots[rd_idx]);
					rd_idx = (rd_idx + 1) % RING_DEPTH;
				end else begin
					pending.push_back(kee_pkg::EV_NONE);
				end
				return;
			end
			rising = keys & ~last_keys;
			if (!fn) begin
				for (int k = 0; k < KEY_W; k++) begin
					if (rising[k])
						push(key_event(k));
				end
			end
			if (enter && !last_enter)
				push(kee_pkg::EV_APPROVE);
			if (del && !last_delete)
				push(kee_pkg::EV_BACK);
			last_keys   = keys;
			last_enter  = enter;
			last_delete = del;
		endfunction

		function void check_event(logic [kee_pkg::CODE_W-1:0] code);
			kee_pkg::event_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: event_code %0d arrived with none expected", $time, code);
				return;
			end
			want = pending.pop_front();
			if (code !== want) begin
				errors++;
				$display("%0t: event_code expected %0d, got %0d", $time, want, code);
			end
		endfunction

	endclass

	logic clk;
	logic arst_n;

	kee_cmd_if cmd_bus ();
	kee_evt_if evt_bus ();

	key_event_edge_queue #(
		.QUEUE_DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.evt(evt_bus)
	);

	event_ring_predictor ring_model = new();

	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  pop_pct;
	logic [KEY_W-1:0]    scan_keys;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(negedge clk) begin
		evt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && evt_bus.valid && evt_bus.ready)
			ring_model.check_event(evt_bus.event_code);
	end

	task automatic send_word(input bit mode, input logic [KEY_W-1:0] keys, input bit fn,
			input bit enter, input bit del);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.mode        <= mode;
		cmd_bus.held_keys   <= keys;
		cmd_bus.fn_held     <= fn;
		cmd_bus.enter_held  <= enter;
		cmd_bus.delete_held <= del;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		ring_model.note_word(mode, keys, fn, enter, del);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		cmd_bus.valid <= 1'b0;
		while (ring_model.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_word(input int n);
		bit               mode;
		logic [KEY_W-1:0] keys;
		if (n % 40 == 0)
			pop_pct = int'($urandom_range(15, 85));
		mode = ($urandom_range(99) < pop_pct) ? MODE_POP : MODE_SCAN;
		case ($urandom_range(3))
			0:       keys = KEY_W'($urandom);
			1:       keys = KEY_W'(1 << $urandom_range(KEY_W - 1));
			2:       keys = scan_keys ^ KEY_W'(1 << $urandom_range(KEY_W - 1));
			default: keys = '0;
		endcase
		if (mode == MODE_SCAN)
			scan_keys = keys;
		send_word(mode, keys, ($urandom_range(4) == 0), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	initial begin
		arst_n              = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.mode        = MODE_SCAN;
		cmd_bus.held_keys   = '0;
		cmd_bus.fn_held     = 1'b0;
		cmd_bus.enter_held  = 1'b0;
		cmd_bus.delete_held = 1'b0;
		evt_bus.ready       = 1'b0;
		send_idle_pct       = 18;
		recv_idle_pct       = 82;
		pop_pct             = 50;
		scan_keys           = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A pop on an empty ring, then one scan that fills it exactly, then a drop.
		send_word(MODE_POP, '0, 1'b0, 1'b0, 1'b0);
		send_word(MODE_SCAN, '1, 1'b0, 1'b1, 1'b1);
		send_word(MODE_SCAN, '0, 1'b0, 1'b0, 1'b0);
		send_word(MODE_SCAN, 13'h0001, 1'b0, 1'b0, 1'b0);
		repeat (16) send_word(MODE_POP, '1, 1'b1, 1'b1, 1'b1);
		// Fn masks the key edges but still updates the key history.
		send_word(MODE_SCAN, '1, 1'b1, 1'b1, 1'b0);
		send_word(MODE_SCAN, '1, 1'b0, 1'b1, 1'b1);
		repeat (3) send_word(MODE_POP, '0, 1'b0, 1'b0, 1'b0);
		scan_keys = '1;

		for (int phase = 0; phase < 3; phase++) begin
			wait_for_results();
			case (phase)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 545; n++)
				random_word(n);
		end

		wait_for_results();
		repeat (40) @(posedge clk);
		if (ring_model.errors == 0 && ring_model.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
